### rtl/bilinear_upscale_2x_wrap_macros.svh
// assertion macros used by the upscaler result sequencer
`ifndef BILINEAR_UPSCALE_2X_WRAP_MACROS_SVH
`define BILINEAR_UPSCALE_2X_WRAP_MACROS_SVH

// same-cycle implication
`define BU2X_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bu2x same-cycle check failed");

// next-cycle implication
`define BU2X_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bu2x next-cycle check failed");

`endif

### rtl/bu2x_pkg.sv
// types and constants of the bilinear 2x upscaler
`timescale 1ns / 1ps
package bu2x_pkg;
   localparam int CHANNEL_BITS   = 8;
   localparam int OUT_BITS       = CHANNEL_BITS + 2;
   localparam int COORD_BITS     = 11;
   localparam int CSR_DATA_BITS  = 11;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } pix_type;

   localparam int PIX_BITS = $bits(pix_type);

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red_in;
      logic [CHANNEL_BITS-1:0] green_in;
      logic [CHANNEL_BITS-1:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] out_row;
      logic [COORD_BITS-1:0] out_col;
      logic [OUT_BITS-1:0]   red_out;
      logic [OUT_BITS-1:0]   green_out;
      logic [OUT_BITS-1:0]   blue_out;
      logic                  run_end;
   } rsp_type;

   // one 2x2 output block: even row/col of its top-left result and its sources
   typedef struct packed {
      logic [COORD_BITS-1:0] row;
      logic [COORD_BITS-1:0] col;
      pix_type               a;
      pix_type               b;
      pix_type               d;
      pix_type               e;
   } block_type;
endpackage

### rtl/bilinear_upscale_2x_wrap.sv
// top level of the bilinear 2x upscaler with edge wraparound
//
//  channel | ports                          | transfer when
//  req     | req_valid req_ready req_data   | req_valid & req_ready
//  rsp     | rsp_valid rsp_ready rsp_data   | rsp_valid & rsp_ready
//  csr     | csr_we csr_index csr_data      | csr_we
//
// an input pixel causes 0, 4, 8 or 16 results, which leave by the single result port
// one per cycle while rsp_ready holds; the next pixel is taken while the last result waits
// line store reads are registered: a pixel waits in the read stage for its line store data, then
// hands its blocks to the result sequencer in the cycle the sequencer frees up
// synchronous reset clears control only; the line stores need no clearing pass
// a csr write restarts the frame at row 0, column 0
`timescale 1ns / 1ps
module bilinear_upscale_2x_wrap #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bu2x_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bu2x_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [bu2x_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bu2x_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import bu2x_pkg::*;

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int DWW   = $clog2(MAX_WIDTH + 1);
   localparam int DHW   = $clog2(MAX_HEIGHT + 1);
   localparam int CMPW  = 14;
   localparam int W_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
   localparam int H_RST = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

   // frame geometry, clamped on write
   logic [DWW-1:0] width_ff, width_in;
   logic [DHW-1:0] height_ff, height_in;
   logic [CMPW-1:0] csr_wide;

   // position of the next pixel
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic          a_last_col, a_last_row;

   // read stage: pixel waiting for its line store data
   logic          b_valid_ff, b_valid_in;
   pix_type       b_cur_ff;
   logic [CW-1:0] b_col_ff;
   logic [RW-1:0] b_row_ff;
   logic          b_last_col_ff, b_last_row_ff;
   logic          b_fwd_prior_ff, b_fwd_first_ff;
   pix_type       b_fwd_pix_ff;
   logic          b_adv;

   // running context of the current row
   pix_type left_ff, row_start_ff, above_left_ff, above_start_ff;
   pix_type first0_ff, first_prev_ff;

   logic    req_fire;
   logic    emit_free;
   pix_type prior_rd, first_rd;
   pix_type up, first_cur, rs, as, first0;
   logic    b_col_nz, b_row_nz;
   logic [3:0] blk_mask;
   block_type  blk [4];
   logic [COORD_BITS-1:0] row_lo, row_hi, col_lo, col_hi;

   assign csr_wide = CMPW'(csr_data);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we && csr_index == CSR_IMAGE_WIDTH) begin
         priority if (csr_wide == '0)                width_in = DWW'(1);
         else if (csr_wide > CMPW'(MAX_WIDTH))       width_in = DWW'(MAX_WIDTH);
         else                                        width_in = DWW'(csr_wide);
      end
      if (csr_we && csr_index == CSR_IMAGE_HEIGHT) begin
         priority if (csr_wide == '0)                height_in = DHW'(1);
         else if (csr_wide > CMPW'(MAX_HEIGHT))      height_in = DHW'(MAX_HEIGHT);
         else                                        height_in = DHW'(csr_wide);
      end
   end

   // handshake: accept while the read stage is empty or about to hand off
   assign b_adv     = b_valid_ff && emit_free;
   assign req_ready = !b_valid_ff || emit_free;
   assign req_fire  = req_valid && req_ready;

   assign a_last_col = (CMPW'(col_ff) + CMPW'(1)) >= CMPW'(width_ff);
   assign a_last_row = (CMPW'(row_ff) + CMPW'(1)) >= CMPW'(height_ff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_we) begin
         col_in = '0;
         row_in = '0;
      end else if (req_fire) begin
         if (a_last_col) begin
            col_in = '0;
            row_in = a_last_row ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   assign b_valid_in = req_fire || (b_valid_ff && !b_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= DWW'(W_RST);
         height_ff  <= DHW'(H_RST);
         col_ff     <= '0;
         row_ff     <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         b_valid_ff <= b_valid_in;
      end
   end

   // capture the accepted pixel; forward a same-address write that lands this edge
   always_ff @(posedge clock) begin
      if (req_fire) begin
         b_cur_ff       <= pix_type'(req_data);
         b_col_ff       <= col_ff;
         b_row_ff       <= row_ff;
         b_last_col_ff  <= a_last_col;
         b_last_row_ff  <= a_last_row;
         b_fwd_prior_ff <= b_adv && (b_col_ff == col_ff);
         b_fwd_first_ff <= b_adv && (b_row_ff == '0) && (b_col_ff == col_ff);
         b_fwd_pix_ff   <= b_cur_ff;
      end
   end

   bu2x_line_mem #(.DEPTH(MAX_WIDTH), .WIDTH(PIX_BITS)) u_prior_row (
      .clock   (clock),
      .wr_en   (b_adv),
      .wr_addr (b_col_ff),
      .wr_data (b_cur_ff),
      .rd_en   (req_fire),
      .rd_addr (col_ff),
      .rd_data (prior_rd)
   );

   bu2x_line_mem #(.DEPTH(MAX_WIDTH), .WIDTH(PIX_BITS)) u_first_row (
      .clock   (clock),
      .wr_en   (b_adv && b_row_ff == '0),
      .wr_addr (b_col_ff),
      .wr_data (b_cur_ff),
      .rd_en   (req_fire),
      .rd_addr (col_ff),
      .rd_data (first_rd)
   );

   // neighbours of the pixel in the read stage
   assign b_col_nz  = (b_col_ff != '0);
   assign b_row_nz  = (b_row_ff != '0);
   assign up        = b_fwd_prior_ff ? b_fwd_pix_ff : prior_rd;
   // on row 0 the first row is this row, so take the pixel itself
   assign first_cur = !b_row_nz ? b_cur_ff :
                      (b_fwd_first_ff ? b_fwd_pix_ff : first_rd);
   assign rs        = b_col_nz ? row_start_ff : b_cur_ff;
   assign as        = b_col_nz ? above_start_ff : up;
   assign first0    = (!b_row_nz && !b_col_nz) ? b_cur_ff : first0_ff;

   // even output coordinates of the four candidate blocks
   assign row_hi = COORD_BITS'({b_row_ff, 1'b0});
   assign row_lo = COORD_BITS'({b_row_ff - RW'(1), 1'b0});
   assign col_hi = COORD_BITS'({b_col_ff, 1'b0});
   assign col_lo = COORD_BITS'({b_col_ff - CW'(1), 1'b0});

   always_comb begin
      // block above-left of the pixel
      blk[0] = '{row: row_lo, col: col_lo, a: above_left_ff, b: up,
                 d: left_ff, e: b_cur_ff};
      // block above, right side wraps to column 0
      blk[1] = '{row: row_lo, col: col_hi, a: up, b: as, d: b_cur_ff, e: rs};
      // block left on the last row, lower side wraps to row 0
      blk[2] = '{row: row_hi, col: col_lo, a: left_ff, b: b_cur_ff,
                 d: first_prev_ff, e: first_cur};
      // corner block of the last row and last column
      blk[3] = '{row: row_hi, col: col_hi, a: b_cur_ff, b: rs, d: first_cur, e: first0};
      blk_mask[0] = b_row_nz && b_col_nz;
      blk_mask[1] = b_row_nz && b_last_col_ff;
      blk_mask[2] = b_last_row_ff && b_col_nz;
      blk_mask[3] = b_last_row_ff && b_last_col_ff;
   end

   // row context commits as the pixel leaves the read stage
   always_ff @(posedge clock) begin
      if (b_adv) begin
         left_ff       <= b_cur_ff;
         above_left_ff <= up;
         first_prev_ff <= first_cur;
         first0_ff     <= first0;
         row_start_ff  <= rs;
         above_start_ff <= as;
      end
   end

   bu2x_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .load        (b_adv),
      .load_mask   (blk_mask),
      .load_blocks (blk),
      .free        (emit_free),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );
endmodule

### rtl/bu2x_line_mem.sv
// line store: one write port, one read port with registered data
`timescale 1ns / 1ps
module bu2x_line_mem #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 24
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

### rtl/bu2x_emit.sv
// result sequencer: walks up to four 2x2 blocks, one result per cycle while rsp_ready is high
`timescale 1ns / 1ps
module bu2x_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic [3:0]          load_mask,
   input  bu2x_pkg::block_type load_blocks [4],
   output logic                free,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output bu2x_pkg::rsp_type   rsp_data
);
   import bu2x_pkg::*;

   logic [3:0] mask_ff, mask_in;
   logic [1:0] quarter_ff, quarter_in;
   block_type  blocks_ff [4];
   block_type  cur_blk;
   logic [3:0] cur_bit;
   logic       fire;
   logic       last;

   function automatic logic [OUT_BITS-1:0] mix(input logic [1:0] q,
      input logic [CHANNEL_BITS-1:0] a, input logic [CHANNEL_BITS-1:0] b,
      input logic [CHANNEL_BITS-1:0] d, input logic [CHANNEL_BITS-1:0] e);
      logic [OUT_BITS-1:0] r;
      unique case (q)
         2'd0:    r = {a, 2'b00};
         2'd1:    r = {OUT_BITS'({1'b0, a} + {1'b0, b})} << 1;
         2'd2:    r = {OUT_BITS'({1'b0, a} + {1'b0, d})} << 1;
         default: r = OUT_BITS'(a) + OUT_BITS'(b) + OUT_BITS'(d) + OUT_BITS'(e);
      endcase
      return r;
   endfunction

   // lowest pending block goes first
   assign cur_bit = mask_ff & (~mask_ff + 4'd1);

   always_comb begin
      cur_blk = blocks_ff[0];
      priority if (cur_bit[0]) cur_blk = blocks_ff[0];
      else if (cur_bit[1])     cur_blk = blocks_ff[1];
      else if (cur_bit[2])     cur_blk = blocks_ff[2];
      else                     cur_blk = blocks_ff[3];
   end

   assign rsp_valid = (mask_ff != 4'd0);
   assign fire      = rsp_valid && rsp_ready;
   assign last      = (quarter_ff == 2'd3) && ((mask_ff & ~cur_bit) == 4'd0);
   assign free      = !rsp_valid || (fire && last);

   always_comb begin
      rsp_data.out_row   = cur_blk.row | COORD_BITS'(quarter_ff[1]);
      rsp_data.out_col   = cur_blk.col | COORD_BITS'(quarter_ff[0]);
      rsp_data.red_out   = mix(quarter_ff, cur_blk.a.red, cur_blk.b.red,
                               cur_blk.d.red, cur_blk.e.red);
      rsp_data.green_out = mix(quarter_ff, cur_blk.a.green, cur_blk.b.green,
                               cur_blk.d.green, cur_blk.e.green);
      rsp_data.blue_out  = mix(quarter_ff, cur_blk.a.blue, cur_blk.b.blue,
                               cur_blk.d.blue, cur_blk.e.blue);
      rsp_data.run_end   = last;
   end

   always_comb begin
      mask_in    = mask_ff;
      quarter_in = quarter_ff;
      if (load) begin
         mask_in    = load_mask;
         quarter_in = 2'd0;
      end else if (fire) begin
         quarter_in = quarter_ff + 2'd1;
         if (quarter_ff == 2'd3) begin
            mask_in = mask_ff & ~cur_bit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff    <= 4'd0;
         quarter_ff <= 2'd0;
      end else begin
         mask_ff    <= mask_in;
         quarter_ff <= quarter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         blocks_ff <= load_blocks;
      end
   end

   `include "bilinear_upscale_2x_wrap_macros.svh"
   `BU2X_ASSERT_IMP(a_load_when_free, clock, reset, load, free)
   `BU2X_ASSERT_NXT(a_quiet_after_end, clock, reset, fire && last && !load, !rsp_valid)
   `BU2X_ASSERT_NXT(a_quarter_wraps, clock, reset, fire && !load && quarter_ff == 2'd3, quarter_ff == 2'd0)
   `BU2X_ASSERT_IMP(a_end_on_last_quarter, clock, reset, rsp_valid && rsp_data.run_end, quarter_ff == 2'd3)
endmodule
